[src/nec_pkg.sv]
// ----------------------------------------------------------------------------
// nec_pkg
// Shared types and codes for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nec_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned BIT_CNT_W  = $clog2(FRAME_BITS);

  // Result status codes
  localparam logic [2:0] ST_IGNORED   = 3'd0;
  localparam logic [2:0] ST_LEADER    = 3'd1;
  localparam logic [2:0] ST_BIT       = 3'd2;
  localparam logic [2:0] ST_FRAME_OK  = 3'd3;
  localparam logic [2:0] ST_FRAME_ERR = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_LEADER_CENTER    = 2'd0;
  localparam logic [1:0] REG_LEADER_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_ONE_THRESHOLD    = 2'd2;

  // Configuration reset values
  localparam logic [7:0] RST_LEADER_CENTER    = 8'd135;
  localparam logic [5:0] RST_LEADER_TOLERANCE = 6'd5;
  localparam logic [7:0] RST_ONE_THRESHOLD    = 8'd20;

  typedef struct packed {
    logic [7:0] leader_center;
    logic [5:0] leader_tolerance;
    logic [7:0] one_threshold;
  } cfg_t;

  typedef struct packed {
    logic                  in_frame;
    logic [BIT_CNT_W-1:0]  bit_cnt;
    logic [FRAME_BITS-1:0] frame_bits;
    logic [31:0]           bad_frames;
    logic [31:0]           good_frames;
  } frame_st_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        clear_timer;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [31:0] error_count;
    logic [31:0] frame_count;
  } result_t;

endpackage

`default_nettype wire

[src/nec_in_if.sv]
// ----------------------------------------------------------------------------
// nec_in_if
// Capture timestamp channel (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface nec_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

`default_nettype wire

[src/nec_out_if.sv]
// ----------------------------------------------------------------------------
// nec_out_if
// Decode result channel (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface nec_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        clear_timer;
  logic [7:0]  address;
  logic [7:0]  command;
  logic [31:0] error_count;
  logic [31:0] frame_count;

  modport source (output valid, output status, output clear_timer, output address,
                  output command, output error_count, output frame_count,
                  input ready);
  modport sink   (input valid, input status, input clear_timer, input address,
                  input command, input error_count, input frame_count,
                  output ready);
endinterface

`default_nettype wire

[src/nec_cfg_if.sv]
// ----------------------------------------------------------------------------
// nec_cfg_if
// Configuration register write channel (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface nec_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/nec_decode.sv]
// ----------------------------------------------------------------------------
// nec_decode
// Single-pass frame decode: width, leader window, bit shift, frame check.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_decode
  import nec_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire cfg_t                                   cfg,
  input  wire frame_st_t                              st,
  input  wire logic [((TIMER_BITS < 16) ? TIMER_BITS : 16)-1:0] last_time,
  input  wire logic [15:0]                            capture_time,
  output frame_st_t                                   st_nxt,
  output logic [((TIMER_BITS < 16) ? TIMER_BITS : 16)-1:0] last_time_nxt,
  output result_t                                     res
);

  localparam int unsigned NOW_W = (TIMER_BITS < 16) ? TIMER_BITS : 16;
  localparam int unsigned CW    = TIMER_BITS + 1;

  logic [NOW_W-1:0]      now;
  logic [TIMER_BITS-1:0] width;
  logic [CW-1:0]         width_x;
  logic                  is_leader;
  logic                  bit_val;
  logic [FRAME_BITS-1:0] shifted;
  logic                  last_bit;
  logic                  cmd_ok;

  assign now     = capture_time[NOW_W-1:0];
  assign width   = TIMER_BITS'(now) - TIMER_BITS'(last_time);
  assign width_x = CW'(width);

  // strictly inside center +/- tolerance
  assign is_leader = ((width_x + CW'(cfg.leader_tolerance)) > CW'(cfg.leader_center)) &&
                     (width_x < (CW'(cfg.leader_center) + CW'(cfg.leader_tolerance)));
  assign bit_val   = width_x > CW'(cfg.one_threshold);

  // LSB first: shift in at the top, first bit lands at bit 0 after a full frame
  assign shifted  = {bit_val, st.frame_bits[FRAME_BITS-1:1]};
  assign last_bit = st.bit_cnt == BIT_CNT_W'(FRAME_BITS - 1);
  assign cmd_ok   = shifted[23:16] == ~shifted[31:24];

  always_comb begin
    st_nxt        = st;
    last_time_nxt = now;
    res.status      = ST_IGNORED;
    res.clear_timer = 1'b0;
    res.address     = 8'd0;
    res.command     = 8'd0;
    if (is_leader) begin
      last_time_nxt     = '0;
      st_nxt.in_frame   = 1'b1;
      st_nxt.bit_cnt    = '0;
      st_nxt.frame_bits = '0;
      res.status        = ST_LEADER;
      res.clear_timer   = 1'b1;
    end else if (st.in_frame) begin
      st_nxt.frame_bits = shifted;
      st_nxt.bit_cnt    = st.bit_cnt + BIT_CNT_W'(1);
      res.status        = ST_BIT;
      if (last_bit) begin
        st_nxt.in_frame = 1'b0;
        st_nxt.bit_cnt  = '0;
        if (cmd_ok) begin
          st_nxt.good_frames = st.good_frames + 32'd1;
          res.status         = ST_FRAME_OK;
          res.address        = shifted[7:0];
          res.command        = shifted[23:16];
        end else begin
          st_nxt.bad_frames = st.bad_frames + 32'd1;
          res.status        = ST_FRAME_ERR;
        end
      end
    end
    res.error_count = st_nxt.bad_frames;
    res.frame_count = st_nxt.good_frames;
  end

endmodule

`default_nettype wire

[src/nec_ir_frame_decoder.sv]
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder working on edge capture timestamps.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake     payload
//   in_if     in    valid/ready   capture_time[15:0]
//   out_if    out   valid/ready   status, clear_timer, address, command,
//                                 error_count, frame_count
//   cfg_if    in    valid/ready   index[1:0], data[7:0] (always ready)
//
// One transaction per clock sustained while out_if is ready: input register,
// then decode into the result register. The decode state updates in the
// same cycle the result register loads, so the next item sees it at once.
// rst_n is synchronous, active low: clears valids, frame state, counters and
// restores the register defaults. When out_if stalls, the input register
// holds one more item and in_if.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame_decoder
  import nec_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nec_in_if.sink    in_if,
  nec_out_if.source out_if,
  nec_cfg_if.sink   cfg_if
);

  localparam int unsigned NOW_W = (TIMER_BITS < 16) ? TIMER_BITS : 16;

  // configuration registers
  cfg_t cfg_r;

  // input register
  logic        in_v_r;
  logic [15:0] in_time_r;

  // decode state
  frame_st_t        st_r;
  frame_st_t        st_nxt;
  logic [NOW_W-1:0] last_time_r;
  logic [NOW_W-1:0] last_time_nxt;

  // result register
  logic    out_v_r;
  result_t res_r;
  result_t res_nxt;

  logic advance;
  logic in_take;

  // decode fires when the input register holds an item and the result
  // register is empty or being drained this cycle
  assign advance = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;
  assign in_take = in_if.valid && in_if.ready;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_center    <= RST_LEADER_CENTER;
      cfg_r.leader_tolerance <= RST_LEADER_TOLERANCE;
      cfg_r.one_threshold    <= RST_ONE_THRESHOLD;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_LEADER_CENTER:    cfg_r.leader_center    <= cfg_if.data;
        REG_LEADER_TOLERANCE: cfg_r.leader_tolerance <= cfg_if.data[5:0];
        REG_ONE_THRESHOLD:    cfg_r.one_threshold    <= cfg_if.data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  nec_decode #(
    .TIMER_BITS (TIMER_BITS)
  ) u_decode (
    .cfg           (cfg_r),
    .st            (st_r),
    .last_time     (last_time_r),
    .capture_time  (in_time_r),
    .st_nxt        (st_nxt),
    .last_time_nxt (last_time_nxt),
    .res           (res_nxt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_time_r <= in_if.capture_time;
    end
  end

  // decode state commits with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      last_time_r <= '0;
    end else if (advance) begin
      st_r        <= st_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.status      = res_r.status;
  assign out_if.clear_timer = res_r.clear_timer;
  assign out_if.address     = res_r.address;
  assign out_if.command     = res_r.command;
  assign out_if.error_count = res_r.error_count;
  assign out_if.frame_count = res_r.frame_count;

endmodule

`default_nettype wire

[tb/tb_nec_ir_frame_decoder.sv]
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_decoder
// Self-checking bench for the NEC infrared frame decoder. Timestamp
// transactions drive a behavioral decoder that queues the expected results.
// Every output transaction is checked field by field against that queue.
// Directed checks cover the leader window edges, the timer wrap and the
// register map. Randomized frame traffic then runs under several register
// settings, with random gaps on the input side and random stalls on the
// output side.
// ----------------------------------------------------------------------------

module tb_nec_ir_frame_decoder
  import nec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // Far above the slowest legal run: ~1000 transactions, each one with at
  // worst a long input gap plus a long output stall.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Pipeline depth is two; the drain leaves room for stray results.
  localparam int DRAIN_CYCLES  = 8;

  logic clk;
  logic rst_n;

  nec_in_if  in_ch ();
  nec_out_if out_ch ();
  nec_cfg_if cfg_ch ();

  nec_ir_frame_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Clock: 20 ns period
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder: register copy and frame state
  // --------------------------------------------------------------------------
  int unsigned  cfg_center;
  int unsigned  cfg_tolerance;
  int unsigned  cfg_threshold;

  logic [15:0]  last_edge;    // reference time; zeroed on every leader
  int unsigned  bit_pos;      // next bit slot in the frame, LSB first
  bit           framing;      // a leader has opened a frame
  logic [31:0]  frame_word;
  logic [31:0]  bad_frames;
  logic [31:0]  good_frames;

  result_t      expected_results[$];

  int           errors;
  int unsigned  edges_sent;
  int unsigned  cycle_count;
  bit           quiet;        // when set, neither side idles
  int           stall_left;
  result_t      want;

  // Strict window on both sides. Sums are done at 32 bits, so a tolerance
  // above the center pulls the lower edge below every width.
  function automatic bit is_leader(int unsigned w);
    return (w + cfg_tolerance > cfg_center) && (w < cfg_center + cfg_tolerance);
  endfunction

  task automatic decoder_reset();
    cfg_center    = RST_LEADER_CENTER;
    cfg_tolerance = RST_LEADER_TOLERANCE;
    cfg_threshold = RST_ONE_THRESHOLD;
    last_edge     = '0;
    bit_pos       = 0;
    framing       = 1'b0;
    frame_word    = '0;
    bad_frames    = '0;
    good_frames   = '0;
  endtask

  // One timestamp in, exactly one result queued.
  task automatic decode_edge(logic [15:0] stamp);
    logic [15:0] width;
    result_t     r;
    width     = stamp - last_edge;   // wraps modulo the 16-bit timer
    last_edge = stamp;
    r         = '0;
    r.status  = ST_IGNORED;
    if (is_leader(width)) begin
      // Timer is told to restart, so the reference drops to zero. A leader
      // inside a frame throws away the bits gathered so far.
      last_edge     = '0;
      bit_pos       = 0;
      framing       = 1'b1;
      frame_word    = '0;
      r.status      = ST_LEADER;
      r.clear_timer = 1'b1;
    end else if (framing) begin
      frame_word[bit_pos] = (width > cfg_threshold);
      bit_pos++;
      r.status = ST_BIT;
      if (bit_pos == FRAME_BITS) begin
        bit_pos = 0;
        framing = 1'b0;
        // Only the command byte is checked against its inverse.
        if (frame_word[23:16] == ~frame_word[31:24]) begin
          good_frames++;
          r.status  = ST_FRAME_OK;
          r.address = frame_word[7:0];
          r.command = frame_word[23:16];
        end else begin
          bad_frames++;
          r.status = ST_FRAME_ERR;
        end
      end
    end
    r.error_count = bad_frames;
    r.frame_count = good_frames;
    expected_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then long
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    if (quiet) begin
      stall_left   = 0;
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else begin
      stall_left   = idle_len();
      out_ch.ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus primitives
  // --------------------------------------------------------------------------

  // Send one timestamp transaction, then predict once it is taken. On return
  // valid is still high; the caller's next step starts on a falling edge.
  task automatic send_edge(logic [15:0] stamp);
    repeat (idle_len()) begin
      @(negedge clk);
      in_ch.valid        = 1'b0;
      in_ch.capture_time = 16'($urandom);   // garbage while idle
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.capture_time = stamp;
    do @(posedge clk); while (!in_ch.ready);
    edges_sent++;
    decode_edge(stamp);
  endtask

  // Timestamp placed a given width after the current reference.
  task automatic send_width(int unsigned w);
    logic [15:0] stamp;
    stamp = last_edge + w[15:0];
    send_edge(stamp);
  endtask

  // Drop valid and let every queued result come back.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with the decoder drained.
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_LEADER_CENTER:    cfg_center    = data;
      REG_LEADER_TOLERANCE: cfg_tolerance = data[5:0];
      REG_ONE_THRESHOLD:    cfg_threshold = data;
      default: ;            // unmapped index: no effect
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Width pickers for well-formed traffic
  // --------------------------------------------------------------------------
  function automatic int unsigned leader_width();
    int unsigned lo;
    if (cfg_tolerance == 0) return $urandom_range(0, 65535);   // empty window
    lo = (cfg_center + 1 > cfg_tolerance) ? cfg_center - cfg_tolerance + 1 : 0;
    return $urandom_range(lo, cfg_center + cfg_tolerance - 1);
  endfunction

  // Width that decodes to the wanted bit without tripping the leader window.
  // Some settings leave no such width; the last try is then sent as is.
  function automatic int unsigned bit_width(bit one);
    int unsigned w;
    repeat (32) begin
      if (!one)
        w = $urandom_range(0, cfg_threshold);
      else if ($urandom_range(0, 3) != 0)
        w = $urandom_range(cfg_threshold + 1, cfg_threshold + 60);
      else
        w = $urandom_range(cfg_threshold + 1, 65535);
      if (!is_leader(w)) return w;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values: window 131..139, ones above 20.
  task automatic test_leader_window();
    send_edge(16'h0000);      // zero width, no frame yet
    send_edge(16'hFFFF);      // largest width, ignored
    send_width(130);          // just below the window
    send_width(140);          // just above the window
    send_width(131);          // lowest leader
    send_width(139);          // highest leader, restarts the frame
    send_width(20);           // equals threshold: zero
    send_width(21);           // one
    send_width(135);          // leader mid-frame drops the two bits
    send_width(255);
  endtask

  // Width taken across the 16-bit rollover.
  task automatic test_timer_wrap();
    send_edge(16'hFFC0);
    send_edge(16'hFFC0 + 16'd135);
  endtask

  task automatic test_register_map();
    wait_idle();
    write_reg(REG_UNMAPPED, 8'hFF);
    send_width(135);                          // still a leader
    wait_idle();
    write_reg(REG_LEADER_TOLERANCE, 8'hFF);   // upper bits masked: 63
    write_reg(REG_LEADER_CENTER, 8'h00);
    send_width(0);                            // window reaches below zero
    send_width(62);
    send_width(63);                           // first width outside
    wait_idle();
    write_reg(REG_LEADER_CENTER, 8'hFF);
    write_reg(REG_ONE_THRESHOLD, 8'hFF);
    send_width(193);                          // window 193..317
    send_width(192);
    send_width(317);
    send_width(318);                          // one above the top of the window
    wait_idle();
    write_reg(REG_ONE_THRESHOLD, 8'h00);
    send_width(0);                            // zero threshold: only 0 is a zero
    send_width(1);
  endtask

  // Mostly whole frames with random bytes, the rest noise and cut frames.
  task automatic test_random_traffic(int unsigned center, int unsigned tol,
                                     int unsigned thr, int unsigned n, bit no_idle);
    int unsigned first;
    int          pick;
    logic [31:0] word;
    logic [7:0]  cmd;
    wait_idle();
    write_reg(REG_LEADER_CENTER, center[7:0]);
    write_reg(REG_LEADER_TOLERANCE, tol[7:0]);
    write_reg(REG_ONE_THRESHOLD, thr[7:0]);
    quiet = no_idle;
    first = edges_sent;
    while (edges_sent - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        cmd  = 8'($urandom);
        word = {($urandom_range(0, 3) != 0) ? ~cmd : 8'($urandom), cmd, 16'($urandom)};
        send_width(leader_width());
        for (int i = 0; i < FRAME_BITS; i++) send_width(bit_width(word[i]));
      end else if (pick < 90) begin
        send_width($urandom_range(0, 65535));
      end else begin
        send_width(leader_width());
        repeat ($urandom_range(1, FRAME_BITS - 1)) send_width(bit_width($urandom_range(0, 1)));
      end
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: oldest expectation against each output transaction
  // --------------------------------------------------------------------------
  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction, status %0d", out_ch.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status",      want.status,      out_ch.status);
        check_field("clear_timer", want.clear_timer, out_ch.clear_timer);
        check_field("address",     want.address,     out_ch.address);
        check_field("command",     want.command,     out_ch.command);
        check_field("error_count", want.error_count, out_ch.error_count);
        check_field("frame_count", want.frame_count, out_ch.frame_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nec_ir_frame_decoder test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.capture_time = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    rst_n              = 1'b0;
    errors             = 0;
    edges_sent         = 0;
    cycle_count        = 0;
    quiet              = 1'b0;
    stall_left         = 0;
    decoder_reset();

    // Synchronous reset held, then released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_leader_window();
    test_timer_wrap();
    test_register_map();

    // Register settings: defaults, then extremes, then random; one phase runs with no idling.
    test_random_traffic(RST_LEADER_CENTER, RST_LEADER_TOLERANCE, RST_ONE_THRESHOLD,
                        100, 1'b0);
    test_random_traffic(135, 5, 20, 150, 1'b1);
    test_random_traffic(255, 63, 255, 150, 1'b0);
    test_random_traffic(0, 63, 0, 80, 1'b0);     // every width below 63 is a leader
    test_random_traffic(200, 0, 50, 60, 1'b0);   // empty window: no leader is recognized
    test_random_traffic(10, 1, 128, 100, 1'b0);  // single-width window
    repeat (2)
      test_random_traffic($urandom_range(0, 255), $urandom_range(1, 63),
                          $urandom_range(0, 255), 150, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("nec_ir_frame_decoder test passed");
    else
      $display("nec_ir_frame_decoder test failed");
    $finish;
  end

endmodule

[files.f]
src/nec_pkg.sv
src/nec_in_if.sv
src/nec_out_if.sv
src/nec_cfg_if.sv
src/nec_decode.sv
src/nec_ir_frame_decoder.sv
tb/tb_nec_ir_frame_decoder.sv
